// File: rtl/tcpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_pkg
// Shared types and constants of the six-step commutation and duty block.
// ----------------------------------------------------------------------------
package tcpd_pkg;

  localparam int unsigned InWidth  = 152;
  localparam int unsigned OutWidth = 56;

  localparam logic [2:0] RegCurrentMode = 3'd0;
  localparam logic [2:0] RegOpenLoop    = 3'd1;
  localparam logic [2:0] RegReverseDir  = 3'd2;
  localparam logic [2:0] RegDutyLimit   = 3'd3;
  localparam logic [2:0] RegGainA0      = 3'd4;
  localparam logic [2:0] RegGainA1      = 3'd5;
  localparam logic [2:0] RegGainA2      = 3'd6;
  localparam logic [2:0] RegFeedForward = 3'd7;

  localparam logic [2:0] SectorLast = 3'd5;

  typedef struct packed {
    logic        start;
    logic [15:0] rem_init;
    logic [14:0] dividend_lo;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/tcpd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_div
// Restoring divider that produces a 15-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module tcpd_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcpd_pkg::div_req_t req_i,
  output tcpd_pkg::div_rsp_t      rsp_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] dvd_q, dvd_d;
  logic [15:0] div_q, div_d;
  logic [16:0] trial;
  logic [16:0] diff;

  assign trial = {rem_q, dvd_q[14]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = 4'd0;
      rem_d = req_i.rem_init;
      dvd_d = req_i.dividend_lo;
      div_d = req_i.divisor;
    end else if (run_q) begin
      if (diff[16]) begin
        rem_d = trial[15:0];
        dvd_d = {dvd_q[13:0], 1'b0};
      end else begin
        rem_d = diff[15:0];
        dvd_d = {dvd_q[13:0], 1'b1};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd14) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule
`default_nettype wire

// File: rtl/trap_commutation_pi_duty_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trap_commutation_pi_duty_top
// Six-step commutation with a q31 PID loop, bus limit clamp and duty divide.
// ----------------------------------------------------------------------------
// A result follows its request through four multiplier passes, add, clamp
// and magnitude, one divider launch, fifteen quotient steps, and collection
// into the output register. A saturated or low-bus duty skips the divider.
// A new request is taken only once the last result has been registered for
// output, and an unread result stalls it. Reset is asynchronous, active
// low, and restores control state and configuration but not the datapath.
// ----------------------------------------------------------------------------
module trap_commutation_pi_duty_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // bus_voltage, bus_current, setpoint, angle_step, comm_ticks, start_req,
  // start_sector, zero pad.
  input  wire logic [tcpd_pkg::InWidth-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // sector_out, duty_out, angle_out, limited, vbus_low, zero pad.
  output logic [tcpd_pkg::OutWidth-1:0]      m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StPid  = 3'd2;
  localparam logic [2:0] StCmd  = 3'd3;
  localparam logic [2:0] StAbs  = 3'd4;
  localparam logic [2:0] StDiv0 = 3'd5;
  localparam logic [2:0] StDivW = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] cnt_q;

  logic        cur_mode_q, open_loop_q, rev_q;
  logic [14:0] dlim_q;
  logic [31:0] a0_q, a1_q, a2_q, ff_q;

  logic [31:0]            angle_q;
  logic [2:0]             sector_q;
  logic [COUNT_WIDTH-1:0] ticks_q;
  logic [31:0]            errp_q, errp2_q, pidp_q;

  logic [30:0] vbus_q;
  logic [31:0] e_q;
  logic [63:0] prod_q, acc_q;
  logic [30:0] lim_q;
  logic [31:0] pid_q;
  logic [32:0] cmd_q, mag_q;
  logic        neg_q;
  logic [15:0] duty_q;
  logic        limited_q, vlow_q;

  logic                          m_valid_q;
  logic [tcpd_pkg::OutWidth-1:0] m_data_q;

  logic [30:0]            in_vbus;
  logic [31:0]            in_ibus, in_sp, in_step;
  logic [15:0]            in_ticks;
  logic                   in_start;
  logic [2:0]             in_ssec;
  logic                   accept;
  logic [31:0]            nx_angle;
  logic [2:0]             nx_sector;
  logic [COUNT_WIDTH-1:0] nx_ticks;
  logic [32:0]            diff;
  logic signed [32:0]     mul_a, mul_b;
  logic signed [65:0]     mul_p;
  logic [32:0]            cmd_sum;
  logic                   over;
  logic [15:0]            dvs;
  logic [14:0]            quot_w;
  tcpd_pkg::div_req_t     div_req;
  tcpd_pkg::div_rsp_t     div_rsp;

  assign in_vbus  = s_axis_tdata[30:0];
  assign in_ibus  = s_axis_tdata[62:31];
  assign in_sp    = s_axis_tdata[94:63];
  assign in_step  = s_axis_tdata[126:95];
  assign in_ticks = s_axis_tdata[142:127];
  assign in_start = s_axis_tdata[143];
  assign in_ssec  = s_axis_tdata[146:144];

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    logic [COUNT_WIDTH-1:0] reload;
    logic [31:0]            ang;
    logic [2:0]             sec;
    logic [COUNT_WIDTH-1:0] tk;
    reload = COUNT_WIDTH'(in_ticks);
    ang    = angle_q;
    sec    = sector_q;
    tk     = ticks_q;
    if (in_start) begin
      ang = 32'd0;
      tk  = reload;
      sec = (in_ssec > tcpd_pkg::SectorLast) ? 3'd0 : in_ssec;
    end
    ang = ang + in_step;
    if (open_loop_q) begin
      if (tk == '0) begin
        tk = reload;
        if (rev_q) begin
          sec = (sec == 3'd0) ? tcpd_pkg::SectorLast : sec - 3'd1;
        end else begin
          sec = (sec >= tcpd_pkg::SectorLast) ? 3'd0 : sec + 3'd1;
        end
      end
      tk = tk - COUNT_WIDTH'(1);
    end
    nx_angle  = ang;
    nx_sector = sec;
    nx_ticks  = tk;
  end

  assign diff = {in_sp[31], in_sp} - {in_ibus[31], in_ibus};

  always_comb begin
    case (cnt_q)
      2'd0: begin
        mul_a = {a0_q[31], a0_q};
        mul_b = {e_q[31], e_q};
      end
      2'd1: begin
        mul_a = {a1_q[31], a1_q};
        mul_b = {errp_q[31], errp_q};
      end
      2'd2: begin
        mul_a = {a2_q[31], a2_q};
        mul_b = {errp2_q[31], errp2_q};
      end
      default: begin
        mul_a = {2'b00, vbus_q};
        mul_b = {18'd0, dlim_q};
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign cmd_sum = {pid_q[31], pid_q} + {ff_q[31], ff_q};
  assign over    = $signed(cmd_sum) > $signed({2'b00, lim_q});
  assign dvs     = vbus_q[30:15];

  always_comb begin
    div_req.start       = (state_q == StDiv0) && (dvs != 16'd0) &&
                          (mag_q < {2'b00, dvs, 15'd0});
    div_req.rem_init    = mag_q[30:15];
    div_req.dividend_lo = mag_q[14:0];
    div_req.divisor     = dvs;
  end

  tcpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quot_w = div_rsp.quot;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = StMul;
      StMul:  if (cnt_q == 2'd3) state_d = StPid;
      StPid:  state_d = StCmd;
      StCmd:  state_d = StAbs;
      StAbs:  state_d = StDiv0;
      StDiv0: state_d = div_req.start ? StDivW : StDone;
      StDivW: if (div_rsp.done) state_d = StDone;
      StDone: if (!m_valid_q || m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= 2'd0;
      cur_mode_q  <= 1'b0;
      open_loop_q <= 1'b1;
      rev_q       <= 1'b0;
      dlim_q      <= 15'h7FFF;
      a0_q        <= 32'd0;
      a1_q        <= 32'd0;
      a2_q        <= 32'd0;
      ff_q        <= 32'd0;
      angle_q     <= 32'd0;
      sector_q    <= 3'd0;
      ticks_q     <= '0;
      errp_q      <= 32'd0;
      errp2_q     <= 32'd0;
      pidp_q      <= 32'd0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tcpd_pkg::RegCurrentMode: cur_mode_q  <= cfg_data_i[0];
          tcpd_pkg::RegOpenLoop:    open_loop_q <= cfg_data_i[0];
          tcpd_pkg::RegReverseDir:  rev_q       <= cfg_data_i[0];
          tcpd_pkg::RegDutyLimit:   dlim_q      <= cfg_data_i[14:0];
          tcpd_pkg::RegGainA0:      a0_q        <= cfg_data_i;
          tcpd_pkg::RegGainA1:      a1_q        <= cfg_data_i;
          tcpd_pkg::RegGainA2:      a2_q        <= cfg_data_i;
          tcpd_pkg::RegFeedForward: ff_q        <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        angle_q  <= nx_angle;
        sector_q <= nx_sector;
        ticks_q  <= nx_ticks;
        cnt_q    <= 2'd0;
        if (!cur_mode_q) pidp_q <= in_sp;
      end
      if (state_q == StMul) cnt_q <= cnt_q + 2'd1;
      if (state_q == StPid) begin
        errp2_q <= errp_q;
        errp_q  <= e_q;
        pidp_q  <= acc_q[62:31] + pidp_q;
      end
      if ((state_q == StCmd) && over) pidp_q <= {1'b0, lim_q};
      if ((state_q == StDone) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vbus_q <= in_vbus;
      e_q    <= cur_mode_q ? {diff[32], diff[32:2]} : 32'd0;
    end
    if (state_q == StMul) begin
      prod_q <= mul_p[63:0];
      acc_q  <= (cnt_q == 2'd0) ? 64'd0 : acc_q + prod_q;
    end
    if (state_q == StPid) begin
      pid_q <= acc_q[62:31] + pidp_q;
      lim_q <= prod_q[45:15];
    end
    if (state_q == StCmd) begin
      cmd_q     <= over ? {2'b00, lim_q} : cmd_sum;
      limited_q <= over;
    end
    if (state_q == StAbs) begin
      neg_q <= cmd_q[32];
      mag_q <= cmd_q[32] ? (~cmd_q + 33'd1) : cmd_q;
    end
    if (state_q == StDiv0) begin
      vlow_q <= (dvs == 16'd0);
      if (dvs == 16'd0) begin
        duty_q <= 16'd0;
      end else begin
        duty_q <= neg_q ? 16'h8000 : 16'h7FFF;
      end
    end
    if ((state_q == StDivW) && div_rsp.done) begin
      duty_q <= neg_q ? (16'd0 - {1'b0, quot_w}) : {1'b0, quot_w};
    end
    if ((state_q == StDone) && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {3'd0, vlow_q, limited_q, angle_q, duty_q, sector_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

// File: rtl/tcpd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_checker
// Port-level checks of the commutation and duty block, bound to its top level.
// ----------------------------------------------------------------------------
module tcpd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [tcpd_pkg::OutWidth-1:0] m_axis_tdata
);

  property p_busy_after_request;
    @(posedge clk_i) disable iff (!rst_ni)
      (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready;
  endproperty
  a_busy_after_request: assert property (p_busy_after_request)
    else $error("input side ready again right after a request");

  property p_result_held;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata));
  endproperty
  a_result_held: assert property (p_result_held)
    else $error("stalled result changed or dropped");

  property p_sector_range;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd6) && (m_axis_tdata[2:0] != 3'd7);
  endproperty
  a_sector_range: assert property (p_sector_range)
    else $error("sector out of range");

  property p_low_bus_zero_duty;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tdata[52]) |-> (m_axis_tdata[18:3] == 16'd0);
  endproperty
  a_low_bus_zero_duty: assert property (p_low_bus_zero_duty)
    else $error("nonzero duty with low bus voltage");

endmodule

bind trap_commutation_pi_duty_top tcpd_checker u_tcpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
